[hw/rtl/kpr_pkg.sv]
`default_nettype none

package kpr_pkg;

	localparam int DefaultPortWidth = 16;
	localparam int KeyWidth = 16;
	localparam int CountWidth = 10;
	localparam int StepWidth = 8;
	localparam int CfgIndexWidth = 8;
	localparam int CfgDataWidth = 16;

	localparam logic [KeyWidth-1:0] KeyMaskReset = 16'hFFFF;
	localparam logic [CountWidth-1:0] RepeatInitialReset = 10'd600;
	localparam logic [CountWidth-1:0] RepeatFloorReset = 10'd5;
	localparam logic [StepWidth-1:0] RepeatStepReset = 8'd10;

	localparam logic [CfgIndexWidth-1:0] RegKeyMask = 8'd0;
	localparam logic [CfgIndexWidth-1:0] RegRepeatInitial = 8'd1;
	localparam logic [CfgIndexWidth-1:0] RegRepeatFloor = 8'd2;
	localparam logic [CfgIndexWidth-1:0] RegRepeatStep = 8'd3;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_DOWN,
		EV_REPEAT,
		EV_UP
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVENT,
		ST_HELD
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/key_press_repeat_events_top.sv]
// Key scanner with debounce confirmation and accelerating auto-repeat.
// Input channel s_axis: one beat per scan carries two samples of an active-low
// key port, the first taken at the start of the scan and the second after the
// debounce delay. A key is pressed when both samples show a masked bit low.
// Output channel m_axis: one beat per scan carries the status and event code
// in tuser and the masked key value in tdata.
// Configuration channel cfg: writes key_mask, repeat_initial, repeat_floor and
// repeat_step by index; it is always ready and should be used while idle.
// Each output beat appears in the cycle after its input beat. Unless the output
// stalls, one scan is accepted every cycle; the state update and the output
// register sit behind a single stage of logic with one 10-bit decrement and one
// add and compare. When the receiver stalls, the output beat holds and
// s_axis_tready follows m_axis_tready, so no beat is lost or repeated.
// Reset clears the event state to none, loads both the countdown and the
// repeat period with 600, clears the held value and restores the register
// defaults; the output channel comes up empty.
`default_nettype none

module key_press_repeat_events_top #(
	parameter int PORT_WIDTH = kpr_pkg::DefaultPortWidth
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [31:0]                       s_axis_tdata,  // first_sample, confirm_sample
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [15:0]                            m_axis_tdata,  // key_value
	output logic [3:0]                             m_axis_tuser,  // status, event_res
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [kpr_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [kpr_pkg::CfgDataWidth-1:0]  cfg_data
);
	import kpr_pkg::*;

	localparam int KeyBits = (PORT_WIDTH < KeyWidth) ? PORT_WIDTH : KeyWidth;
	localparam logic [KeyWidth-1:0] PortMask = KeyWidth'((33'd1 << KeyBits) - 33'd1);

	logic [KeyWidth-1:0]   key_mask_q;
	logic [CountWidth-1:0] repeat_initial_q;
	logic [CountWidth-1:0] repeat_floor_q;
	logic [StepWidth-1:0]  repeat_step_q;

	event_t                event_state_q, event_state_n;
	logic [CountWidth-1:0] hold_countdown_q, hold_countdown_n;
	logic [CountWidth-1:0] repeat_period_q, repeat_period_n;
	logic [KeyWidth-1:0]   held_value_q, held_value_n;

	status_t               status_q, status_n;
	event_t                event_res_q, event_res_n;
	logic [KeyWidth-1:0]   key_value_q, key_value_n;
	logic                  out_valid_q;

	logic                  in_accept;
	logic [KeyWidth-1:0]   keys;
	logic [KeyWidth-1:0]   first_sample;
	logic [KeyWidth-1:0]   confirm_sample;
	logic                  pressed;
	logic [CountWidth-1:0] count_dec;
	logic [CountWidth:0]   floor_plus_step;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign keys = key_mask_q & PortMask;
	assign first_sample = s_axis_tdata[15:0] & PortMask;
	assign confirm_sample = s_axis_tdata[31:16] & PortMask;
	assign pressed = ((first_sample & keys) != keys) && ((confirm_sample & keys) != keys);
	assign count_dec = hold_countdown_q - 10'd1;
	assign floor_plus_step = {1'b0, repeat_floor_q} + (CountWidth+1)'(repeat_step_q);

	always_comb begin
		event_state_n = event_state_q;
		hold_countdown_n = hold_countdown_q;
		repeat_period_n = repeat_period_q;
		held_value_n = held_value_q;
		status_n = ST_IDLE;
		event_res_n = EV_NONE;
		key_value_n = '0;
		if (pressed) begin
			held_value_n = confirm_sample & keys;
			key_value_n = confirm_sample & keys;
			if (event_state_q inside {EV_NONE, EV_UP}) begin
				event_state_n = EV_DOWN;
				hold_countdown_n = repeat_initial_q;
				repeat_period_n = repeat_initial_q;
				status_n = ST_EVENT;
				event_res_n = EV_DOWN;
			end else if (count_dec == '0) begin
				if ({1'b0, repeat_period_q} <= floor_plus_step) begin
					repeat_period_n = repeat_floor_q;
				end else begin
					repeat_period_n = repeat_period_q - CountWidth'(repeat_step_q);
				end
				hold_countdown_n = repeat_period_n;
				event_state_n = EV_REPEAT;
				status_n = ST_EVENT;
				event_res_n = EV_REPEAT;
			end else begin
				hold_countdown_n = count_dec;
				status_n = ST_HELD;
				event_res_n = event_state_q;
			end
		end else if (event_state_q inside {EV_DOWN, EV_REPEAT}) begin
			event_state_n = EV_UP;
			hold_countdown_n = repeat_initial_q;
			status_n = ST_EVENT;
			event_res_n = EV_UP;
			key_value_n = held_value_q;
		end else begin
			held_value_n = '0;
			event_state_n = EV_NONE;
			hold_countdown_n = repeat_initial_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mask_q <= KeyMaskReset;
			repeat_initial_q <= RepeatInitialReset;
			repeat_floor_q <= RepeatFloorReset;
			repeat_step_q <= RepeatStepReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegKeyMask: key_mask_q <= cfg_data[KeyWidth-1:0];
				RegRepeatInitial: repeat_initial_q <= cfg_data[CountWidth-1:0];
				RegRepeatFloor: repeat_floor_q <= cfg_data[CountWidth-1:0];
				RegRepeatStep: repeat_step_q <= cfg_data[StepWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_state_q <= EV_NONE;
			hold_countdown_q <= RepeatInitialReset;
			repeat_period_q <= RepeatInitialReset;
			held_value_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				event_state_q <= event_state_n;
				hold_countdown_q <= hold_countdown_n;
				repeat_period_q <= repeat_period_n;
				held_value_q <= held_value_n;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_q <= status_n;
			event_res_q <= event_res_n;
			key_value_q <= key_value_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = key_value_q;
	assign m_axis_tuser = {event_res_q, status_q};

	a_idle_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_IDLE |-> event_res_q == EV_NONE && key_value_q == '0)
		else $error("idle result carries an event or a key value");

	a_held_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_HELD |->
			event_res_q == EV_DOWN || event_res_q == EV_REPEAT)
		else $error("held result without a down or repeat event");

	a_no_repeat_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (event_state_q == EV_NONE || event_state_q == EV_UP) |=>
			event_state_q != EV_REPEAT)
		else $error("repeat entered without a prior press");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> out_valid_q && !m_axis_tready)
		else $error("input blocked while output can move");

endmodule

`default_nettype wire
